@@ rtl/core/ebm_pkg.sv @@
package ebm_pkg;

    localparam int TOKEN_W     = 10;
    localparam int ELEM_W      = 6;
    localparam int WEIGHT_W    = 16;
    localparam int SUM_W       = 24;
    localparam int CNT_FIELD_W = 16;
    localparam int VOCAB_CFG_W = 11;
    localparam int DIMS_CFG_W  = 7;
    localparam int CFG_W       = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // input kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    // commands queued from front to back
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_FLAG  = 2'd3;

    // configuration register indexes
    localparam logic CFG_VOCAB = 1'b0;
    localparam logic CFG_DIMS  = 1'b1;

    localparam logic [VOCAB_CFG_W-1:0] VOCAB_RESET = 11'd1024;
    localparam logic [DIMS_CFG_W-1:0]  DIMS_RESET  = 7'd64;

    localparam logic signed [SUM_W:0] SUM_MAX = 25'sd8388607;
    localparam logic signed [SUM_W:0] SUM_MIN = -25'sd8388608;

    localparam logic [SUM_W-1:0]    QUO_POS_MAX = 24'd32767;
    localparam logic [SUM_W-1:0]    QUO_NEG_MAX = 24'd32768;
    localparam logic [WEIGHT_W-1:0] MEAN_POS_MAX = 16'h7FFF;
    localparam logic [WEIGHT_W-1:0] MEAN_NEG_MAX = 16'h8000;

    typedef struct packed {
        logic [1:0]                 op;
        logic [TOKEN_W-1:0]         token;
        logic [ELEM_W-1:0]          element;
        logic signed [WEIGHT_W-1:0] weight;
        logic [CNT_FIELD_W-1:0]     count;
    } cmd_t;

endpackage

@@ rtl/core/ebm_queue.sv @@
module ebm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ebm_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output ebm_pkg::cmd_t pop_data,
    output logic          empty
);
    import ebm_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic [QPTR_W:0]   fill_next;

    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/ebm_front.sv @@
module ebm_front #(
    parameter int VOCAB   = 1024,
    parameter int DIM     = 64,
    parameter int MAX_BAG = 255
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_kind,
    input  logic [ebm_pkg::TOKEN_W-1:0]       s_token,
    input  logic [ebm_pkg::ELEM_W-1:0]        s_element,
    input  logic signed [ebm_pkg::WEIGHT_W-1:0] s_weight,
    input  logic [ebm_pkg::VOCAB_CFG_W-1:0]   vocab_in_use,
    output logic                              q_push,
    output ebm_pkg::cmd_t                     q_data,
    input  logic                              q_full
);
    import ebm_pkg::*;

    localparam int CNT_W = $clog2(MAX_BAG + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             accept;
    logic             write_ok;
    logic             token_ok;
    logic             bag_full;

    assign s_ready  = !q_full;
    assign accept   = s_valid && !q_full;
    assign write_ok = (32'(s_token) < VOCAB) && (32'(s_element) < DIM);
    assign token_ok = (32'(s_token) < VOCAB) && ({1'b0, s_token} < vocab_in_use);
    assign bag_full = (cnt_reg == CNT_W'(MAX_BAG));

    always_comb begin
        q_push         = 1'b0;
        q_data.op      = CMD_WRITE;
        q_data.token   = s_token;
        q_data.element = s_element;
        q_data.weight  = s_weight;
        q_data.count   = CNT_FIELD_W'(cnt_reg);
        cnt_next       = cnt_reg;
        unique case (s_kind)
            KIND_WRITE: begin
                q_push = accept && write_ok;
            end
            KIND_ADD: begin
                q_push = accept;
                if (token_ok && !bag_full) begin
                    q_data.op = CMD_ADD;
                    if (accept) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end else begin
                    q_data.op = CMD_FLAG;
                end
            end
            KIND_CLOSE: begin
                q_push    = accept;
                q_data.op = CMD_CLOSE;
                if (accept) begin
                    cnt_next = '0;
                end
            end
            default: begin
                // unknown kind: drop
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/core/ebm_div.sv @@
module ebm_div #(
    parameter int CNT_W = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ebm_pkg::SUM_W-1:0]  dividend,
    input  logic [CNT_W-1:0]           divisor,
    output logic                       done,
    output logic [ebm_pkg::SUM_W-1:0]  quotient
);
    import ebm_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_diff;
    logic              ge;
    logic [CNT_W-1:0]  rem_new;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_diff = rem_sh - {1'b0, dvs_reg};
        rem_new  = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_new;
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
        end
    end

endmodule

@@ rtl/core/ebm_back.sv @@
module ebm_back #(
    parameter int VOCAB   = 1024,
    parameter int DIM     = 64,
    parameter int MAX_BAG = 255
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_empty,
    output logic                                 q_pop,
    input  ebm_pkg::cmd_t                        q_data,
    input  logic [ebm_pkg::ELEM_W-1:0]           dim_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ebm_pkg::ELEM_W-1:0]           m_element_res,
    output logic signed [ebm_pkg::WEIGHT_W-1:0]  m_mean_value,
    output logic                                 m_error,
    output logic                                 m_last
);
    import ebm_pkg::*;

    localparam int ROWS      = (VOCAB < (1 << TOKEN_W)) ? VOCAB : (1 << TOKEN_W);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int EL_W      = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int TBL_DEPTH = ROWS * (1 << EL_W);
    localparam int ADDR_W    = ROW_W + EL_W;
    localparam int CNT_W     = $clog2(MAX_BAG + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADD   = 3'd1;
    localparam logic [2:0] ST_C_RD  = 3'd2;
    localparam logic [2:0] ST_C_LD  = 3'd3;
    localparam logic [2:0] ST_C_DIV = 3'd4;
    localparam logic [2:0] ST_C_OUT = 3'd5;

    logic signed [WEIGHT_W-1:0] tbl_mem [TBL_DEPTH];
    logic signed [SUM_W-1:0]    sum_mem [DIM];

    logic [2:0]                 state_reg, state_next;
    logic [EL_W-1:0]            d_reg, d_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       p_valid_reg, p_valid_next;
    logic [EL_W-1:0]            p_d_reg, p_d_next;
    logic                       err_reg, err_next;
    logic [DIM-1:0]             sval_reg;
    logic                       neg_reg, neg_next;
    logic [WEIGHT_W-1:0]        res_reg, res_next;
    logic signed [WEIGHT_W-1:0] tbl_rd_reg;
    logic signed [SUM_W-1:0]    sum_rd_reg;
    logic                       m_valid_reg;
    logic [ELEM_W-1:0]          m_elem_reg;
    logic [WEIGHT_W-1:0]        m_mean_reg;
    logic                       m_err_reg;
    logic                       m_last_reg;

    logic                       tbl_we;
    logic [ADDR_W-1:0]          tbl_addr;
    logic signed [SUM_W-1:0]    old_sum;
    logic signed [SUM_W:0]      sum_ext;
    logic signed [SUM_W-1:0]    sum_wdata;
    logic                       sat;
    logic signed [SUM_W-1:0]    cur_sum;
    logic                       cur_neg;
    logic [SUM_W-1:0]           cur_abs;
    logic                       div_start;
    logic                       div_done;
    logic [SUM_W-1:0]           div_quo;
    logic [WEIGHT_W-1:0]        quo_clamped;
    logic                       out_free;
    logic                       out_load;
    logic                       last_d;
    logic                       sval_clear;

    assign last_d   = (d_reg == dim_last[EL_W-1:0]);
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty && !p_valid_reg;
    assign tbl_we   = q_pop && (q_data.op == CMD_WRITE);
    assign tbl_addr = tbl_we ? {q_data.token[ROW_W-1:0], q_data.element[EL_W-1:0]}
                             : {row_reg, d_reg};

    // accumulate stage: one dimension per cycle, saturating
    always_comb begin
        old_sum   = sval_reg[p_d_reg] ? sum_rd_reg : '0;
        sum_ext   = {old_sum[SUM_W-1], old_sum}
                  + {{(SUM_W+1-WEIGHT_W){tbl_rd_reg[WEIGHT_W-1]}}, tbl_rd_reg};
        sat       = 1'b0;
        sum_wdata = sum_ext[SUM_W-1:0];
        if (sum_ext > SUM_MAX) begin
            sat       = 1'b1;
            sum_wdata = SUM_MAX[SUM_W-1:0];
        end else if (sum_ext < SUM_MIN) begin
            sat       = 1'b1;
            sum_wdata = SUM_MIN[SUM_W-1:0];
        end
    end

    always_comb begin
        cur_sum   = sval_reg[d_reg] ? sum_rd_reg : '0;
        cur_neg   = cur_sum[SUM_W-1];
        cur_abs   = cur_neg ? (~cur_sum + 1'b1) : cur_sum;
        div_start = (state_reg == ST_C_LD) && (cnt_reg != '0);
        if (neg_reg) begin
            quo_clamped = (div_quo > QUO_NEG_MAX) ? MEAN_NEG_MAX
                                                  : (~div_quo[WEIGHT_W-1:0] + 1'b1);
        end else begin
            quo_clamped = (div_quo > QUO_POS_MAX) ? MEAN_POS_MAX : div_quo[WEIGHT_W-1:0];
        end
    end

    ebm_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cur_abs),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next   = state_reg;
        d_next       = d_reg;
        row_next     = row_reg;
        cnt_next     = cnt_reg;
        p_valid_next = 1'b0;
        p_d_next     = p_d_reg;
        err_next     = err_reg;
        neg_next     = neg_reg;
        res_next     = res_reg;
        out_load     = 1'b0;
        sval_clear   = 1'b0;
        if (p_valid_reg && sat) begin
            err_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    unique case (q_data.op)
                        CMD_WRITE: begin
                            state_next = ST_IDLE;
                        end
                        CMD_ADD: begin
                            row_next   = q_data.token[ROW_W-1:0];
                            d_next     = '0;
                            state_next = ST_ADD;
                        end
                        CMD_CLOSE: begin
                            cnt_next   = q_data.count[CNT_W-1:0];
                            d_next     = '0;
                            state_next = ST_C_RD;
                        end
                        CMD_FLAG: begin
                            err_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_ADD: begin
                p_valid_next = 1'b1;
                p_d_next     = d_reg;
                if (last_d) begin
                    state_next = ST_IDLE;
                end else begin
                    d_next = d_reg + 1'b1;
                end
            end
            ST_C_RD: begin
                state_next = ST_C_LD;
            end
            ST_C_LD: begin
                neg_next = cur_neg;
                if (cnt_reg == '0) begin
                    res_next   = '0;
                    state_next = ST_C_OUT;
                end else begin
                    state_next = ST_C_DIV;
                end
            end
            ST_C_DIV: begin
                if (div_done) begin
                    res_next   = quo_clamped;
                    state_next = ST_C_OUT;
                end
            end
            ST_C_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (last_d) begin
                        sval_clear = 1'b1;
                        err_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        d_next     = d_reg + 1'b1;
                        state_next = ST_C_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            d_reg       <= '0;
            cnt_reg     <= '0;
            p_valid_reg <= 1'b0;
            err_reg     <= 1'b0;
            sval_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            d_reg       <= d_next;
            cnt_reg     <= cnt_next;
            p_valid_reg <= p_valid_next;
            err_reg     <= err_next;
            if (sval_clear) begin
                sval_reg <= '0;
            end else if (p_valid_reg) begin
                sval_reg[p_d_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        p_d_reg <= p_d_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        if (out_load) begin
            m_elem_reg <= ELEM_W'(d_reg);
            m_mean_reg <= res_reg;
            m_err_reg  <= err_reg;
            m_last_reg <= last_d;
        end
    end

    // weight table: single port
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_addr] <= q_data.weight;
        end
        tbl_rd_reg <= tbl_mem[tbl_addr];
    end

    // running sums: one write, one read
    always_ff @(posedge aclk) begin
        if (p_valid_reg) begin
            sum_mem[p_d_reg] <= sum_wdata;
        end
        sum_rd_reg <= sum_mem[d_reg];
    end

    assign m_valid       = m_valid_reg;
    assign m_element_res = m_elem_reg;
    assign m_mean_value  = m_mean_reg;
    assign m_error       = m_err_reg;
    assign m_last        = m_last_reg;

    a_add_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD && last_d) |=> (state_reg == ST_IDLE && p_valid_reg))
        else $error("add did not drain its last accumulate");

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_d) |=> (sval_reg == '0 && !err_reg && state_reg == ST_IDLE))
        else $error("bag not cleared after close");

    a_close_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !last_d) |=> (state_reg == ST_C_RD && d_reg == $past(d_reg) + 1'b1))
        else $error("close did not advance to next dimension");

    a_div_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_C_DIV && div_done) |=> (state_reg == ST_C_OUT))
        else $error("quotient not taken");

    a_sum_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> (p_d_reg <= dim_last[EL_W-1:0]))
        else $error("sum written beyond dimensions in use");

endmodule

@@ rtl/core/embedding_bag_mean.sv @@
// Write word: written to the table when popped at the back end, after a 4-entry queue.
// Add word: one table element per cycle, plus a pop and a sum drain.
// Close word: per dimension in use a sum read, a 24-step radix-2 divider (skipped for
// an empty bag), an output load, plus any output stall; words are carried out one at a time.
// Reset (aresetn, synchronous, low) clears sums, count, error flag, queue and config
// to vocab 1024 / dims 64; the weight table keeps its contents.
module embedding_bag_mean #(
    parameter int VOCAB   = 1024,
    parameter int DIM     = 64,
    parameter int MAX_BAG = 255
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_kind,
    input  logic [ebm_pkg::TOKEN_W-1:0]          s_token,
    input  logic [ebm_pkg::ELEM_W-1:0]           s_element,
    input  logic signed [ebm_pkg::WEIGHT_W-1:0]  s_weight,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ebm_pkg::ELEM_W-1:0]           m_element_res,
    output logic signed [ebm_pkg::WEIGHT_W-1:0]  m_mean_value,
    output logic                                 m_error,
    output logic                                 m_last,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_addr,
    input  logic [ebm_pkg::CFG_W-1:0]            cfg_wdata
);
    import ebm_pkg::*;

    logic [VOCAB_CFG_W-1:0] vocab_reg;
    logic [DIMS_CFG_W-1:0]  dims_reg;
    logic [DIMS_CFG_W-1:0]  dims_eff;
    logic [ELEM_W-1:0]      dim_last;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    cmd_t                   q_in;
    cmd_t                   q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vocab_reg <= VOCAB_RESET;
            dims_reg  <= DIMS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_VOCAB: vocab_reg <= cfg_wdata[VOCAB_CFG_W-1:0];
                CFG_DIMS:  dims_reg  <= cfg_wdata[DIMS_CFG_W-1:0];
            endcase
        end
    end

    // clamp dimension count to [1, DIM]
    always_comb begin
        if (dims_reg == '0) begin
            dims_eff = DIMS_CFG_W'(1);
        end else if (dims_reg > DIMS_CFG_W'(DIM)) begin
            dims_eff = DIMS_CFG_W'(DIM);
        end else begin
            dims_eff = dims_reg;
        end
        dim_last = ELEM_W'(dims_eff - 1'b1);
    end

    ebm_front #(
        .VOCAB   (VOCAB),
        .DIM     (DIM),
        .MAX_BAG (MAX_BAG)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_token      (s_token),
        .s_element    (s_element),
        .s_weight     (s_weight),
        .vocab_in_use (vocab_reg),
        .q_push       (q_push),
        .q_data       (q_in),
        .q_full       (q_full)
    );

    ebm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    ebm_back #(
        .VOCAB   (VOCAB),
        .DIM     (DIM),
        .MAX_BAG (MAX_BAG)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_data        (q_out),
        .dim_last      (dim_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_element_res (m_element_res),
        .m_mean_value  (m_mean_value),
        .m_error       (m_error),
        .m_last        (m_last)
    );

endmodule

@@ bench/ebm_checker.sv @@
module ebm_checker #(
    parameter int VOCAB   = 1024,
    parameter int DIM     = 64,
    parameter int MAX_BAG = 255
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [1:0]                          s_kind,
    input  logic [ebm_pkg::TOKEN_W-1:0]         s_token,
    input  logic [ebm_pkg::ELEM_W-1:0]          s_element,
    input  logic signed [ebm_pkg::WEIGHT_W-1:0] s_weight,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [ebm_pkg::ELEM_W-1:0]          m_element_res,
    input  logic signed [ebm_pkg::WEIGHT_W-1:0] m_mean_value,
    input  logic                                m_error,
    input  logic                                m_last,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [ebm_pkg::CFG_W-1:0]           cfg_wdata,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  words_checked
);
    import ebm_pkg::*;

    typedef struct packed {
        logic [ELEM_W-1:0]          element;
        logic signed [WEIGHT_W-1:0] mean;
        logic                       error;
        logic                       last;
    } mean_word_t;

    logic signed [WEIGHT_W-1:0] weights [VOCAB*DIM];
    int                         dim_sum [DIM];
    int unsigned                bag_tokens;
    logic                       bag_err;
    logic [VOCAB_CFG_W-1:0]     vocab_cfg;
    logic [DIMS_CFG_W-1:0]      dims_cfg;
    mean_word_t                 means_due [$];

    initial begin
        fail_count    = 0;
        pending       = 0;
        words_checked = 0;
    end

    function automatic int unsigned dims_span();
        int unsigned d;
        d = dims_cfg;
        if (d < 1) d = 1;
        if (d > DIM) d = DIM;
        return d;
    endfunction

    function automatic int unsigned vocab_span();
        return (vocab_cfg < VOCAB) ? vocab_cfg : VOCAB;
    endfunction

    task automatic report_failure(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic accumulate_row(input int unsigned token);
        int s;
        if (token >= vocab_span() || bag_tokens >= MAX_BAG) begin
            // drop the token, keep the bag
            bag_err = 1'b1;
        end else begin
            for (int d = 0; d < dims_span(); d++) begin
                s = dim_sum[d] + int'(weights[token*DIM + d]);
                if (s > int'(SUM_MAX)) begin
                    s = int'(SUM_MAX);
                    bag_err = 1'b1;
                end
                if (s < int'(SUM_MIN)) begin
                    s = int'(SUM_MIN);
                    bag_err = 1'b1;
                end
                dim_sum[d] = s;
            end
            bag_tokens++;
        end
    endtask

    task automatic emit_means();
        int unsigned n;
        int          quo;
        mean_word_t  w;
        n = dims_span();
        for (int d = 0; d < n; d++) begin
            // integer divide truncates toward zero
            quo = (bag_tokens == 0) ? 0 : dim_sum[d] / int'(bag_tokens);
            if (quo > 32767) quo = 32767;
            if (quo < -32768) quo = -32768;
            w.element = d[ELEM_W-1:0];
            w.mean    = quo[WEIGHT_W-1:0];
            w.error   = bag_err;
            w.last    = (d + 1 == n);
            means_due.push_back(w);
        end
        foreach (dim_sum[i]) dim_sum[i] = 0;
        bag_tokens = 0;
        bag_err    = 1'b0;
    endtask

    task automatic take_word();
        case (s_kind)
            KIND_WRITE: begin
                if (int'(s_token) < VOCAB && int'(s_element) < DIM)
                    weights[int'(s_token)*DIM + int'(s_element)] = s_weight;
            end
            KIND_ADD:   accumulate_row(s_token);
            KIND_CLOSE: emit_means();
            default: ;
        endcase
    endtask

    task automatic check_word();
        mean_word_t want;
        words_checked++;
        if (means_due.size() == 0) begin
            report_failure($sformatf("unexpected mean word, element %0d", m_element_res));
        end else begin
            want = means_due.pop_front();
            if (m_element_res !== want.element)
                report_failure($sformatf("element got %0d expected %0d",
                                         m_element_res, want.element));
            if (m_mean_value !== want.mean)
                report_failure($sformatf("element %0d mean got %0d expected %0d",
                                         want.element, m_mean_value, want.mean));
            if (m_error !== want.error)
                report_failure($sformatf("element %0d error got %b expected %b",
                                         want.element, m_error, want.error));
            if (m_last !== want.last)
                report_failure($sformatf("element %0d last got %b expected %b",
                                         want.element, m_last, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (dim_sum[i]) dim_sum[i] = 0;
            bag_tokens = 0;
            bag_err    = 1'b0;
            vocab_cfg  = VOCAB_RESET;
            dims_cfg   = DIMS_RESET;
            means_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_VOCAB) vocab_cfg = cfg_wdata[VOCAB_CFG_W-1:0];
                else dims_cfg = cfg_wdata[DIMS_CFG_W-1:0];
            end
            // check first so a word never matches a close taken on the same edge
            if (m_valid && m_ready) check_word();
            if (s_valid && s_ready) take_word();
        end
        pending = means_due.size();
    end

endmodule

@@ bench/tb_embedding_bag_mean.sv @@
module tb_embedding_bag_mean;
    import ebm_pkg::*;

    localparam int VOCAB         = 1024;
    localparam int DIM           = 64;
    localparam int MAX_BAG       = 255;
    localparam int SETTLE_CYCLES = 400;
    localparam int QUIET_LIMIT   = 6000;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic                       aclk;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_kind    = KIND_WRITE;
    logic [TOKEN_W-1:0]         s_token   = '0;
    logic [ELEM_W-1:0]          s_element = '0;
    logic signed [WEIGHT_W-1:0] s_weight  = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic [ELEM_W-1:0]          m_element_res;
    logic signed [WEIGHT_W-1:0] m_mean_value;
    logic                       m_error;
    logic                       m_last;
    logic                       cfg_wr_en = 1'b0;
    logic                       cfg_addr  = CFG_VOCAB;
    logic [CFG_W-1:0]           cfg_wdata = '0;

    int fail_count;
    int pending;
    int words_checked;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int words_sent    = 0;
    int bags_closed   = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    logic [VOCAB_CFG_W-1:0] vocab_now = VOCAB_RESET;
    logic [DIMS_CFG_W-1:0]  dims_now  = DIMS_RESET;
    bit                     row_init [VOCAB*DIM];
    int                     pool [4];
    int                     vocab_plan [7] = '{16, 1, 0, 1024, 300, 2047, 5};
    int                     dims_plan  [7] = '{5, 1, 127, 0, 3, 2, 2};

    embedding_bag_mean #(
        .VOCAB   (VOCAB),
        .DIM     (DIM),
        .MAX_BAG (MAX_BAG)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_token       (s_token),
        .s_element     (s_element),
        .s_weight      (s_weight),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_element_res (m_element_res),
        .m_mean_value  (m_mean_value),
        .m_error       (m_error),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    ebm_checker #(
        .VOCAB   (VOCAB),
        .DIM     (DIM),
        .MAX_BAG (MAX_BAG)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_token       (s_token),
        .s_element     (s_element),
        .s_weight      (s_weight),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_element_res (m_element_res),
        .m_mean_value  (m_mean_value),
        .m_error       (m_error),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("no word moved for %0d cycles, %0d mean words still due",
                     QUIET_LIMIT, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int live_dims();
        int d;
        d = dims_now;
        if (d < 1) d = 1;
        if (d > DIM) d = DIM;
        return d;
    endfunction

    function automatic int live_vocab();
        return (vocab_now < VOCAB) ? int'(vocab_now) : VOCAB;
    endfunction

    function automatic int pick_weight();
        case ($urandom_range(7))
            0:       return -32768;
            1:       return 32767;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // hold valid through the handshake; go low only for a sender gap
    task automatic send_word(input logic [1:0] kind, input int token, input int element,
                             input int weight);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_token   <= token[TOKEN_W-1:0];
        s_element <= element[ELEM_W-1:0];
        s_weight  <= weight[WEIGHT_W-1:0];
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (kind == KIND_WRITE) row_init[token*DIM + element] = 1'b1;
        if (kind == KIND_CLOSE) bags_closed++;
    endtask

    // write every element the add will read that was never written, before the add itself
    task automatic feed_token(input int token);
        if (token < live_vocab()) begin
            for (int e = 0; e < live_dims(); e++)
                if (!row_init[token*DIM + e])
                    send_word(KIND_WRITE, token, e, pick_weight());
        end
        send_word(KIND_ADD, token, $urandom_range(63), pick_weight());
    endtask

    // drop valid, wait for every mean word, then let queued adds finish
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(input int vocab, input int dims);
        int wd;
        wd = ($urandom_range(15) << DIMS_CFG_W) | dims;
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_VOCAB;
        cfg_wdata <= vocab[CFG_W-1:0];
        @(posedge aclk);
        cfg_addr  <= CFG_DIMS;
        cfg_wdata <= wd[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        vocab_now = vocab[VOCAB_CFG_W-1:0];
        dims_now  = dims[DIMS_CFG_W-1:0];
        settings_used++;
    endtask

    initial begin
        int n_adds;
        int pick;
        int v;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        apply_setting(1000, 4);
        send_word(KIND_CLOSE, 0, 0, 0);
        send_word(KIND_UNUSED, 1023, 63, -1);
        send_word(KIND_WRITE, 0, 0, -32768);
        send_word(KIND_WRITE, 0, 1, 32767);
        send_word(KIND_WRITE, 0, 2, 1);
        send_word(KIND_WRITE, 0, 3, -1);
        send_word(KIND_WRITE, 999, 0, 32767);
        send_word(KIND_WRITE, 999, 1, -32768);
        send_word(KIND_WRITE, 999, 2, 0);
        send_word(KIND_WRITE, 999, 3, 7);
        send_word(KIND_WRITE, 1023, 63, 21845);
        send_word(KIND_ADD, 0, 0, 0);
        send_word(KIND_ADD, 999, 0, 0);
        send_word(KIND_CLOSE, 0, 0, 0);
        send_word(KIND_ADD, 0, 0, 0);
        send_word(KIND_ADD, 0, 0, 0);
        send_word(KIND_ADD, 999, 0, 0);
        send_word(KIND_CLOSE, 0, 0, 0);
        send_word(KIND_ADD, 1000, 0, 0);
        send_word(KIND_ADD, 0, 0, 0);
        send_word(KIND_CLOSE, 0, 0, 0);
        send_word(KIND_ADD, 1023, 0, 0);
        send_word(KIND_CLOSE, 0, 0, 0);
        settle();

        for (int p = 0; p < 7; p++) begin
            apply_setting(vocab_plan[p], dims_plan[p]);
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 75; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase

            // a vocab of zero leaves only rejected tokens
            v = live_vocab();
            for (int k = 0; k < 4; k++)
                pool[k] = (v == 0) ? $urandom_range(VOCAB - 1) : $urandom_range(v - 1);
            if (v != 0) begin
                pool[0] = 0;
                pool[1] = v - 1;
            end

            for (int b = 0; b < 3; b++) begin
                n_adds = ($urandom_range(4) == 0) ? $urandom_range(8, 4) : $urandom_range(3);
                for (int i = 0; i < n_adds; i++) begin
                    pick = $urandom_range(19);
                    if (pick == 0)
                        send_word(KIND_UNUSED, $urandom_range(1023), $urandom_range(63),
                                  pick_weight());
                    else if (pick == 1)
                        send_word(KIND_WRITE, $urandom_range(1023), $urandom_range(63),
                                  pick_weight());
                    else if (pick <= 4 && live_vocab() < VOCAB)
                        feed_token($urandom_range(VOCAB - 1, live_vocab()));
                    else
                        feed_token(pool[$urandom_range(3)]);
                end
                send_word(KIND_CLOSE, $urandom_range(1023), $urandom_range(63), pick_weight());
                if (p == 1 && b == 1) settle();
            end
            settle();
        end

        $display("sent %0d input words, closed %0d bags under %0d register settings",
                 words_sent, bags_closed, settings_used);
        $display("checked %0d mean words: empty and rejected-token bags, %s",
                 words_checked, "clamped vocab and dims, all idle mixes");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
